/* sv/bhpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared widths, operation codes, status codes and register map of the
// binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXTRACT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_HEAP_ORDER = 1'b0;

endpackage

`default_nettype wire

/* sv/bhpq_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_in_if
// Operation channel: valid/ready handshake carrying mode and key.
// ----------------------------------------------------------------------------
interface bhpq_in_if import bhpq_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic signed [KEY_W-1:0] key_in;

  modport source (output valid, output mode, output key_in, input ready);
  modport sink   (input valid, input mode, input key_in, output ready);

endinterface

`default_nettype wire

/* sv/bhpq_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_out_if
// Result channel: valid/ready handshake carrying status, extracted key, root and count.
// ----------------------------------------------------------------------------
interface bhpq_out_if import bhpq_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [KEY_W-1:0] extracted_key;
  logic                    root_valid;
  logic signed [KEY_W-1:0] root_key;
  logic [COUNT_W-1:0]      entry_count;

  modport source (output valid, output status, output extracted_key, output root_valid,
                  output root_key, output entry_count, input ready);
  modport sink   (input valid, input status, input extracted_key, input root_valid,
                  input root_key, input entry_count, output ready);

endinterface

`default_nettype wire

/* sv/binary_heap_priority_queue_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_core
// Array-based max/min heap of signed keys with insert, extract and rebuild.
// Insert sifts the new key up with one parent compare per level; extract moves
//   the last entry to the root and sifts it down; rebuild sifts down each
//   internal node in turn; rejected and unused-code words go straight to done.
// Operations are taken one at a time: a new one is accepted only in the idle
//   state, once the previous result has been taken.
// Reset clears the fill count and the order bit; store contents are left.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_core import bhpq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  bhpq_in_if.sink                 in_ch,
  bhpq_out_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic                    pready,
  output logic      [PDATA_W-1:0] prdata
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CH_W  = IDX_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_EX_RD, S_LOAD, S_RB_NEXT,
    S_DN_RD, S_DN_CMPL, S_DN_CMPR, S_PLACE, S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic [MODE_W-1:0]       mode_r, mode_nxt;
  logic signed [KEY_W-1:0] x_r, x_nxt;
  logic signed [KEY_W-1:0] best_r, best_nxt;
  logic                    left_r, left_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;
  logic signed [KEY_W-1:0] taken_r, taken_nxt;
  logic signed [KEY_W-1:0] root_r, root_nxt;

  logic                    heap_order;
  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic signed [KEY_W-1:0] wdata;
  logic                    re;
  logic [IDX_W-1:0]        raddr_a;
  logic [IDX_W-1:0]        raddr_b;
  logic [KEY_W-1:0]        rdata_a_raw;
  logic [KEY_W-1:0]        rdata_b_raw;
  logic signed [KEY_W-1:0] rdata_a;
  logic signed [KEY_W-1:0] rdata_b;
  logic signed [KEY_W-1:0] cmp_a;
  logic signed [KEY_W-1:0] cmp_b;
  logic                    above;

  logic [IDX_W-1:0]        parent;
  logic [CH_W-1:0]         left_idx;
  logic [CH_W-1:0]         right_idx;
  logic                    left_ok;
  logic                    right_ok;
  logic [CNT_W-1:0]        k_dec;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  bhpq_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .prdata     (prdata),
    .heap_order (heap_order)
  );

  bhpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a_raw),
    .rdata_b (rdata_b_raw)
  );

  assign rdata_a = rdata_a_raw;
  assign rdata_b = rdata_b_raw;

  bhpq_cmp u_cmp (
    .key_a     (cmp_a),
    .key_b     (cmp_b),
    .min_order (heap_order),
    .above     (above)
  );

  assign parent    = (pos_r - IDX_W'(1)) >> 1;
  assign left_idx  = CH_W'({pos_r, 1'b1});
  assign right_idx = left_idx + CH_W'(1);
  assign left_ok   = (left_idx < CH_W'(n_r));
  assign right_ok  = (right_idx < CH_W'(n_r));
  assign k_dec     = k_r - CNT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    pos_nxt    = pos_r;
    mode_nxt   = mode_r;
    x_nxt      = x_r;
    best_nxt   = best_r;
    left_nxt   = left_r;
    status_nxt = status_r;
    taken_nxt  = taken_r;
    we         = 1'b0;
    waddr      = pos_r;
    wdata      = x_r;
    re         = 1'b0;
    raddr_a    = '0;
    raddr_b    = '0;
    cmp_a      = x_r;
    cmp_b      = rdata_a;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt   = in_ch.mode;
          x_nxt      = in_ch.key_in;
          status_nxt = STATUS_OK;
          taken_nxt  = '0;
          state_nxt  = S_DONE;
          case (in_ch.mode)
            MODE_INSERT: begin
              if (cnt_r >= CNT_W'(CAPACITY)) begin
                status_nxt = STATUS_FULL;
              end else begin
                pos_nxt   = cnt_r[IDX_W-1:0];
                cnt_nxt   = cnt_r + CNT_W'(1);
                state_nxt = (cnt_r == '0) ? S_PLACE : S_UP_RD;
              end
            end
            MODE_EXTRACT: begin
              if (cnt_r == '0) begin
                status_nxt = STATUS_EMPTY;
              end else begin
                taken_nxt = root_r;
                cnt_nxt   = cnt_r - CNT_W'(1);
                n_nxt     = cnt_r - CNT_W'(1);
                pos_nxt   = '0;
                if (cnt_r != CNT_W'(1)) begin
                  state_nxt = S_EX_RD;
                end
              end
            end
            MODE_REBUILD: begin
              n_nxt     = cnt_r;
              k_nxt     = cnt_r >> 1;
              state_nxt = S_RB_NEXT;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_UP_RD: begin
        re        = 1'b1;
        raddr_a   = parent;
        state_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        cmp_a = x_r;
        cmp_b = rdata_a;
        if (above) begin
          we        = 1'b1;
          wdata     = rdata_a;
          pos_nxt   = parent;
          state_nxt = (parent == '0) ? S_PLACE : S_UP_RD;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_EX_RD: begin
        re        = 1'b1;
        raddr_a   = n_r[IDX_W-1:0];
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        x_nxt     = rdata_a;
        state_nxt = S_DN_RD;
      end
      S_RB_NEXT: begin
        if (k_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_dec;
          pos_nxt   = k_dec[IDX_W-1:0];
          re        = 1'b1;
          raddr_a   = k_dec[IDX_W-1:0];
          state_nxt = S_LOAD;
        end
      end
      S_DN_RD: begin
        if (!left_ok) begin
          state_nxt = S_PLACE;
        end else begin
          re        = 1'b1;
          raddr_a   = left_idx[IDX_W-1:0];
          raddr_b   = right_idx[IDX_W-1:0];
          state_nxt = S_DN_CMPL;
        end
      end
      S_DN_CMPL: begin
        cmp_a = rdata_a;
        cmp_b = x_r;
        if (right_ok) begin
          best_nxt  = above ? rdata_a : x_r;
          left_nxt  = above;
          state_nxt = S_DN_CMPR;
        end else if (above) begin
          we        = 1'b1;
          wdata     = rdata_a;
          pos_nxt   = left_idx[IDX_W-1:0];
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_DN_CMPR: begin
        cmp_a = rdata_b;
        cmp_b = best_r;
        if (above) begin
          we        = 1'b1;
          wdata     = rdata_b;
          pos_nxt   = right_idx[IDX_W-1:0];
          state_nxt = S_DN_RD;
        end else if (left_r) begin
          we        = 1'b1;
          wdata     = rdata_a;
          pos_nxt   = left_idx[IDX_W-1:0];
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        we        = 1'b1;
        wdata     = x_r;
        state_nxt = (mode_r == MODE_REBUILD) ? S_RB_NEXT : S_DONE;
      end
      S_DONE: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign root_nxt = (we && (waddr == '0)) ? wdata : root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    n_r      <= n_nxt;
    k_r      <= k_nxt;
    pos_r    <= pos_nxt;
    mode_r   <= mode_nxt;
    x_r      <= x_nxt;
    best_r   <= best_nxt;
    left_r   <= left_nxt;
    status_r <= status_nxt;
    taken_r  <= taken_nxt;
    root_r   <= root_nxt;
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_r};

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = (state_r == S_DONE);
  assign out_ch.status        = status_r;
  assign out_ch.extracted_key = taken_r;
  assign out_ch.root_valid    = (cnt_r != '0);
  assign out_ch.root_key      = (cnt_r != '0) ? root_r : '0;
  assign out_ch.entry_count   = cnt_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

/* sv/bhpq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic RAM: one write port, two read ports with registered, enabled read.
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [WIDTH-1:0]  rdata_a,
  output logic      [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

/* sv/bhpq_cmp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_cmp
// Shared key comparator: flags when key a belongs above key b in the heap.
// ----------------------------------------------------------------------------
module bhpq_cmp import bhpq_pkg::*; (
  input  wire logic signed [KEY_W-1:0] key_a,
  input  wire logic signed [KEY_W-1:0] key_b,
  input  wire logic                    min_order,
  output logic                         above
);

  always_comb begin
    if (min_order) begin
      above = (key_a < key_b);
    end else begin
      above = (key_a > key_b);
    end
  end

endmodule

`default_nettype wire

/* sv/bhpq_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_cfg
// APB register block holding the heap order bit.
// ----------------------------------------------------------------------------
module bhpq_cfg import bhpq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic                    pready,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    heap_order
);

  logic                 order_r;
  logic                 order_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 hit;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign hit     = (reg_idx == REG_HEAP_ORDER);
  assign pready  = 1'b1;

  always_comb begin
    order_nxt = order_r;
    if (psel && penable && pwrite && pready && hit) begin
      order_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0;
    end else begin
      order_r <= order_nxt;
    end
  end

  assign prdata     = hit ? {{(PDATA_W-1){1'b0}}, order_r} : '0;
  assign heap_order = order_r;

endmodule

`default_nettype wire
